// File: rtl/lprf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_pkg
// Shared codes and types for the length-prefixed record FIFO.
// ----------------------------------------------------------------------------
package lprf_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_SEL   = 3'd3,
    CMD_PEEK  = 3'd4,
    CMD_DROP  = 3'd5,
    CMD_CLEAR = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 3'd0,
    STS_FULL  = 3'd1,
    STS_EMPTY = 3'd2,
    STS_RANGE = 3'd3,
    STS_SEQ   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_LEN,
    ST_POP_DATA,
    ST_DROP_LEN,
    ST_SEL_WALK,
    ST_PEEK_DATA
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_out;
    logic [BYTE_W-1:0]   record_length;
    logic                last_byte;
    logic [COUNT_W-1:0]  records_stored;
    logic [COUNT_W-1:0]  free_bytes;
  } result_t;

endpackage

// File: rtl/lprf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_if
// Command and result channels of the record FIFO (valid/ready).
// ----------------------------------------------------------------------------
interface lprf_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lprf_pkg::CMD_W-1:0]    cmd;
  logic [lprf_pkg::BYTE_W-1:0]   record_length_in;
  logic [lprf_pkg::BYTE_W-1:0]   data_byte;
  logic [lprf_pkg::INDEX_W-1:0]  record_index;

  modport source (output valid, cmd, record_length_in, data_byte, record_index,
                  input ready);
  modport sink   (input valid, cmd, record_length_in, data_byte, record_index,
                  output ready);
endinterface

interface lprf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lprf_pkg::STATUS_W-1:0] status;
  logic [lprf_pkg::BYTE_W-1:0]   data_out;
  logic [lprf_pkg::BYTE_W-1:0]   record_length;
  logic                          last_byte;
  logic [lprf_pkg::COUNT_W-1:0]  records_stored;
  logic [lprf_pkg::COUNT_W-1:0]  free_bytes;

  modport source (output valid, status, data_out, record_length, last_byte,
                  records_stored, free_bytes, input ready);
  modport sink   (input valid, status, data_out, record_length, last_byte,
                  records_stored, free_bytes, output ready);
endinterface

// File: rtl/lprf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_ram
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lprf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [lprf_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [lprf_pkg::BYTE_W-1:0] rd_data_o
);

  logic [lprf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [lprf_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/length_prefixed_record_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_record_fifo
// Record FIFO over a byte ring; each record is a length byte plus its data.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command per transfer (begin, push, pop, peek select,
//   peek byte, drop, clear); rsp_o returns exactly one result per command.
//   Begin, push, clear, every error and a drop during a pop need no ring read:
//   the result is registered at the accepting edge.
//   Pop of a data byte, peek byte and a plain drop first do one ring read.
//   The first pop of a record reads the length byte, then the data byte
//   unless the length is zero. Peek select walks one length byte per
//   cycle through the single read port of the ring up to record_index.
//   Commands are handled one at a time; req_i.ready is high when the block
//   is idle and the result register is empty or being drained.
//   If rsp_o is stalled, the result holds and no new command is taken.
//   Reset empties the FIFO; ring contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module length_prefixed_record_fifo #(
  parameter int unsigned RING_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lprf_cmd_if.sink          req_i,
  lprf_rsp_if.source        rsp_o
);

  localparam int unsigned AW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
  localparam int unsigned UW = $clog2(RING_BYTES + 1);
  localparam int unsigned SW = ((AW > 9) ? AW : 9) + 1;
  localparam int unsigned BW = lprf_pkg::BYTE_W;

  lprf_pkg::state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [UW-1:0] cnt_q, cnt_d, used_q, used_d;
  logic [BW-1:0] push_rem_q, push_rem_d, pop_rem_q, pop_rem_d;
  logic [BW-1:0] pop_len_q, pop_len_d, peek_rem_q, peek_rem_d;
  logic [BW-1:0] peek_len_q, peek_len_d;
  logic [AW-1:0] peek_ptr_q, peek_ptr_d, walk_ptr_q, walk_ptr_d;
  logic [lprf_pkg::INDEX_W-1:0] walk_cnt_q, walk_cnt_d;

  logic              ov_q, ov_d;
  lprf_pkg::result_t res_q, res;
  logic              res_valid;

  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] wr_data, rd_data;

  logic accept;
  logic idx_ok;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p, input logic [8:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(RING_BYTES)) s = s - SW'(RING_BYTES);
    return s[AW-1:0];
  endfunction

  assign req_i.ready = (state_q == lprf_pkg::ST_IDLE) && (!ov_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign idx_ok      = 32'(req_i.record_index) < 32'(cnt_q);

  lprf_ram #(.DEPTH(RING_BYTES), .AW(AW)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(tail_q),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lprf_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            lprf_pkg::CMD_POP: begin
              if (pop_rem_q != '0) state_d = lprf_pkg::ST_POP_DATA;
              else if (cnt_q != '0) state_d = lprf_pkg::ST_POP_LEN;
            end
            lprf_pkg::CMD_DROP: begin
              if (pop_rem_q == '0 && cnt_q != '0) state_d = lprf_pkg::ST_DROP_LEN;
            end
            lprf_pkg::CMD_SEL: begin
              if (pop_rem_q == '0 && cnt_q != '0 && idx_ok) state_d = lprf_pkg::ST_SEL_WALK;
            end
            lprf_pkg::CMD_PEEK: begin
              if (peek_rem_q != '0) state_d = lprf_pkg::ST_PEEK_DATA;
            end
            default: state_d = lprf_pkg::ST_IDLE;
          endcase
        end
      end
      lprf_pkg::ST_POP_LEN: begin
        state_d = (rd_data == '0) ? lprf_pkg::ST_IDLE : lprf_pkg::ST_POP_DATA;
      end
      lprf_pkg::ST_SEL_WALK: begin
        if (walk_cnt_q == '0) state_d = lprf_pkg::ST_IDLE;
      end
      lprf_pkg::ST_POP_DATA, lprf_pkg::ST_DROP_LEN, lprf_pkg::ST_PEEK_DATA: begin
        state_d = lprf_pkg::ST_IDLE;
      end
      default: state_d = lprf_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    used_d     = used_q;
    push_rem_d = push_rem_q;
    pop_rem_d  = pop_rem_q;
    pop_len_d  = pop_len_q;
    peek_rem_d = peek_rem_q;
    peek_len_d = peek_len_q;
    peek_ptr_d = peek_ptr_q;
    walk_ptr_d = walk_ptr_q;
    walk_cnt_d = walk_cnt_q;
    wr_en      = 1'b0;
    wr_data    = req_i.data_byte;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    res_valid  = 1'b0;
    res.status        = lprf_pkg::STS_OK;
    res.data_out      = '0;
    res.record_length = '0;
    res.last_byte     = 1'b0;

    unique case (state_q)
      lprf_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            lprf_pkg::CMD_BEGIN: begin
              res_valid = 1'b1;
              if (push_rem_q != '0) begin
                res.status = lprf_pkg::STS_SEQ;
              end else if (32'(req_i.record_length_in) + 32'd1 >
                           32'(RING_BYTES) - 32'(used_q)) begin
                res.status = lprf_pkg::STS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_data = req_i.record_length_in;
                tail_d  = ring_add(tail_q, 9'd1);
                used_d  = used_q + UW'(1);
                if (req_i.record_length_in == '0) begin
                  cnt_d         = cnt_q + UW'(1);
                  res.last_byte = 1'b1;
                end else begin
                  push_rem_d = req_i.record_length_in;
                end
              end
            end
            lprf_pkg::CMD_PUSH: begin
              res_valid = 1'b1;
              if (push_rem_q == '0) begin
                res.status = lprf_pkg::STS_SEQ;
              end else begin
                wr_en      = 1'b1;
                tail_d     = ring_add(tail_q, 9'd1);
                used_d     = used_q + UW'(1);
                push_rem_d = push_rem_q - BW'(1);
                if (push_rem_q == BW'(1)) begin
                  cnt_d         = cnt_q + UW'(1);
                  res.last_byte = 1'b1;
                end
              end
            end
            lprf_pkg::CMD_POP: begin
              peek_rem_d = '0;
              rd_en      = 1'b1;
              if (pop_rem_q == '0 && cnt_q == '0) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_EMPTY;
              end
            end
            lprf_pkg::CMD_SEL: begin
              walk_ptr_d = head_q;
              walk_cnt_d = req_i.record_index;
              rd_en      = 1'b1;
              if (pop_rem_q != '0) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_SEQ;
              end else if (cnt_q == '0) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_EMPTY;
              end else if (!idx_ok) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_RANGE;
              end
            end
            lprf_pkg::CMD_PEEK: begin
              rd_en   = 1'b1;
              rd_addr = peek_ptr_q;
              if (peek_rem_q == '0) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_SEQ;
              end
            end
            lprf_pkg::CMD_DROP: begin
              peek_rem_d = '0;
              rd_en      = 1'b1;
              if (pop_rem_q != '0) begin
                // discard the rest of the record being popped
                res_valid         = 1'b1;
                res.record_length = pop_len_q;
                head_d    = ring_add(head_q, {1'b0, pop_rem_q});
                used_d    = used_q - UW'(pop_rem_q);
                cnt_d     = cnt_q - UW'(1);
                pop_rem_d = '0;
              end else if (cnt_q == '0) begin
                res_valid  = 1'b1;
                res.status = lprf_pkg::STS_EMPTY;
              end
            end
            lprf_pkg::CMD_CLEAR: begin
              res_valid  = 1'b1;
              head_d     = '0;
              tail_d     = '0;
              cnt_d      = '0;
              used_d     = '0;
              push_rem_d = '0;
              pop_rem_d  = '0;
              pop_len_d  = '0;
              peek_rem_d = '0;
              peek_len_d = '0;
              peek_ptr_d = '0;
            end
            default: begin
              res_valid  = 1'b1;
              res.status = lprf_pkg::STS_SEQ;
            end
          endcase
        end
      end
      lprf_pkg::ST_POP_LEN: begin
        head_d = ring_add(head_q, 9'd1);
        used_d = used_q - UW'(1);
        if (rd_data == '0) begin
          res_valid     = 1'b1;
          res.last_byte = 1'b1;
          cnt_d         = cnt_q - UW'(1);
        end else begin
          pop_len_d = rd_data;
          pop_rem_d = rd_data;
          rd_en     = 1'b1;
          rd_addr   = ring_add(head_q, 9'd1);
        end
      end
      lprf_pkg::ST_POP_DATA: begin
        res_valid         = 1'b1;
        res.data_out      = rd_data;
        res.record_length = pop_len_q;
        head_d    = ring_add(head_q, 9'd1);
        used_d    = used_q - UW'(1);
        pop_rem_d = pop_rem_q - BW'(1);
        if (pop_rem_q == BW'(1)) begin
          res.last_byte = 1'b1;
          cnt_d         = cnt_q - UW'(1);
        end
      end
      lprf_pkg::ST_DROP_LEN: begin
        res_valid         = 1'b1;
        res.record_length = rd_data;
        head_d = ring_add(head_q, 9'(rd_data) + 9'd1);
        used_d = used_q - UW'(rd_data) - UW'(1);
        cnt_d  = cnt_q - UW'(1);
      end
      lprf_pkg::ST_SEL_WALK: begin
        if (walk_cnt_q == '0) begin
          res_valid         = 1'b1;
          res.record_length = rd_data;
          res.last_byte     = (rd_data == '0);
          peek_len_d = rd_data;
          peek_rem_d = rd_data;
          peek_ptr_d = ring_add(walk_ptr_q, 9'd1);
        end else begin
          // skip over this record and fetch the next length byte
          walk_ptr_d = ring_add(walk_ptr_q, 9'(rd_data) + 9'd1);
          walk_cnt_d = walk_cnt_q - lprf_pkg::INDEX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = walk_ptr_d;
        end
      end
      lprf_pkg::ST_PEEK_DATA: begin
        res_valid         = 1'b1;
        res.data_out      = rd_data;
        res.record_length = peek_len_q;
        res.last_byte     = (peek_rem_q == BW'(1));
        peek_ptr_d = ring_add(peek_ptr_q, 9'd1);
        peek_rem_d = peek_rem_q - BW'(1);
      end
      default: ;
    endcase

    res.records_stored = lprf_pkg::COUNT_W'(32'(cnt_d));
    res.free_bytes     = lprf_pkg::COUNT_W'(32'(RING_BYTES) - 32'(used_d));
    ov_d = res_valid || (ov_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lprf_pkg::ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      used_q     <= '0;
      push_rem_q <= '0;
      pop_rem_q  <= '0;
      pop_len_q  <= '0;
      peek_rem_q <= '0;
      peek_len_q <= '0;
      peek_ptr_q <= '0;
      walk_ptr_q <= '0;
      walk_cnt_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      used_q     <= used_d;
      push_rem_q <= push_rem_d;
      pop_rem_q  <= pop_rem_d;
      pop_len_q  <= pop_len_d;
      peek_rem_q <= peek_rem_d;
      peek_len_q <= peek_len_d;
      peek_ptr_q <= peek_ptr_d;
      walk_ptr_q <= walk_ptr_d;
      walk_cnt_q <= walk_cnt_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.status         = res_q.status;
  assign rsp_o.data_out       = res_q.data_out;
  assign rsp_o.record_length  = res_q.record_length;
  assign rsp_o.last_byte      = res_q.last_byte;
  assign rsp_o.records_stored = res_q.records_stored;
  assign rsp_o.free_bytes     = res_q.free_bytes;

endmodule

// File: rtl/lprf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprf_checker
// Port-level checks on the record FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module lprf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic [lprf_pkg::CMD_W-1:0]    req_cmd_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [lprf_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [lprf_pkg::BYTE_W-1:0]   rsp_data_i,
  input logic [lprf_pkg::COUNT_W-1:0]  rsp_records_i
);

  // a result must hold until it is taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // no new command while a result is stuck at the output
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("command taken while output stalled");

  // clear answers on the next cycle with an empty FIFO
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == lprf_pkg::CMD_CLEAR |=>
      rsp_valid_i && rsp_status_i == lprf_pkg::STS_OK && rsp_records_i == '0)
    else $error("clear result wrong");

  // an error never carries a data byte
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != lprf_pkg::STS_OK |-> rsp_data_i == '0)
    else $error("error result carries data");

endmodule

bind length_prefixed_record_fifo lprf_checker u_lprf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_cmd_i    (req_i.cmd),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.data_out),
  .rsp_records_i(rsp_o.records_stored)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed record FIFO. Commands are driven
// through the request channel in random bursts; a behavioral model of the
// ring predicts each result, and a monitor compares results field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RING = 1024;
  localparam int unsigned WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  lprf_cmd_if req_if ();
  lprf_rsp_if rsp_if ();

  length_prefixed_record_fifo #(.RING_BYTES(RING)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // model state
  logic [7:0]  ring_mem [RING];
  int unsigned head_ptr, tail_ptr, rec_cnt, push_left, pop_left;
  int unsigned peek_ptr, peek_left, used_cnt, pop_len, peek_len;

  lprf_pkg::result_t expected_q[$];
  int                fail_cnt;
  int unsigned       idle_cycles;
  bit                stall_en;

  function automatic void model_clear();
    head_ptr = 0; tail_ptr = 0; rec_cnt = 0; push_left = 0; pop_left = 0;
    peek_ptr = 0; peek_left = 0; used_cnt = 0; pop_len = 0; peek_len = 0;
  endfunction

  function automatic lprf_pkg::result_t predict_result(lprf_pkg::cmd_e c, logic [7:0] len_in,
                                                       logic [7:0] din, logic [9:0] idx);
    lprf_pkg::result_t r;
    int unsigned       p, n;
    r = '0;
    r.status = lprf_pkg::STS_OK;
    case (c)
      lprf_pkg::CMD_BEGIN: begin
        if (push_left != 0) r.status = lprf_pkg::STS_SEQ;
        else if (len_in + 1 > RING - used_cnt) r.status = lprf_pkg::STS_FULL;
        else begin
          ring_mem[tail_ptr] = len_in;
          tail_ptr = (tail_ptr + 1) % RING;
          used_cnt++;
          if (len_in == 0) begin
            rec_cnt++;
            r.last_byte = 1'b1;
          end else push_left = len_in;
        end
      end
      lprf_pkg::CMD_PUSH: begin
        if (push_left == 0) r.status = lprf_pkg::STS_SEQ;
        else begin
          ring_mem[tail_ptr] = din;
          tail_ptr = (tail_ptr + 1) % RING;
          used_cnt++;
          push_left--;
          if (push_left == 0) begin
            rec_cnt++;
            r.last_byte = 1'b1;
          end
        end
      end
      lprf_pkg::CMD_POP: begin
        peek_left = 0;
        if (pop_left == 0 && rec_cnt == 0) r.status = lprf_pkg::STS_EMPTY;
        else begin
          bit zero_rec;
          zero_rec = 1'b0;
          if (pop_left == 0) begin
            pop_len = ring_mem[head_ptr];
            head_ptr = (head_ptr + 1) % RING;
            used_cnt--;
            if (pop_len == 0) begin
              rec_cnt--;
              r.last_byte = 1'b1;
              zero_rec = 1'b1;
            end else pop_left = pop_len;
          end
          if (!zero_rec) begin
            r.record_length = 8'(pop_len);
            r.data_out = ring_mem[head_ptr];
            head_ptr = (head_ptr + 1) % RING;
            used_cnt--;
            pop_left--;
            if (pop_left == 0) begin
              rec_cnt--;
              r.last_byte = 1'b1;
            end
          end
        end
      end
      lprf_pkg::CMD_SEL: begin
        if (pop_left != 0) r.status = lprf_pkg::STS_SEQ;
        else if (rec_cnt == 0) r.status = lprf_pkg::STS_EMPTY;
        else if (idx >= rec_cnt) r.status = lprf_pkg::STS_RANGE;
        else begin
          p = head_ptr;
          for (int i = 0; i < idx; i++) p = (p + 1 + ring_mem[p]) % RING;
          peek_len = ring_mem[p];
          peek_ptr = (p + 1) % RING;
          peek_left = peek_len;
          r.record_length = 8'(peek_len);
          r.last_byte = (peek_len == 0);
        end
      end
      lprf_pkg::CMD_PEEK: begin
        if (peek_left == 0) r.status = lprf_pkg::STS_SEQ;
        else begin
          r.data_out = ring_mem[peek_ptr];
          peek_ptr = (peek_ptr + 1) % RING;
          peek_left--;
          r.record_length = 8'(peek_len);
          r.last_byte = (peek_left == 0);
        end
      end
      lprf_pkg::CMD_DROP: begin
        peek_left = 0;
        if (pop_left == 0 && rec_cnt == 0) r.status = lprf_pkg::STS_EMPTY;
        else begin
          if (pop_left != 0) begin
            n = pop_left;
            r.record_length = 8'(pop_len);
            pop_left = 0;
          end else begin
            r.record_length = ring_mem[head_ptr];
            n = 1 + ring_mem[head_ptr];
          end
          head_ptr = (head_ptr + n) % RING;
          used_cnt -= n;
          rec_cnt--;
        end
      end
      lprf_pkg::CMD_CLEAR: model_clear();
      default: r.status = lprf_pkg::STS_SEQ;
    endcase
    r.records_stored = 11'(rec_cnt);
    r.free_bytes = 11'(RING - used_cnt);
    return r;
  endfunction

  // one command per transfer; valid held through bursts, gaps drawn at random
  task automatic send_cmd(logic [2:0] c, logic [7:0] len_in = 8'd0,
                          logic [7:0] din = 8'd0, logic [9:0] idx = 10'd0);
    if ($urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= c;
    req_if.record_length_in <= len_in;
    req_if.data_byte <= din;
    req_if.record_index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_q.push_back(predict_result(lprf_pkg::cmd_e'(c), len_in, din, idx));
    @(negedge clk_i);
  endtask

  task automatic idle_req();
    req_if.valid <= 1'b0;
  endtask

  // write a full record: a begin with its length, then one push per data byte
  task automatic write_record(int unsigned len);
    send_cmd(lprf_pkg::CMD_BEGIN, len[7:0]);
    for (int i = 0; i < len; i++) send_cmd(lprf_pkg::CMD_PUSH, 8'd0, 8'($urandom));
  endtask

  task automatic test_directed();
    send_cmd(lprf_pkg::CMD_POP);
    send_cmd(lprf_pkg::CMD_DROP);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'd0);
    send_cmd(lprf_pkg::CMD_PEEK);
    send_cmd(lprf_pkg::CMD_PUSH, 8'd0, 8'hff);
    send_cmd(3'd7);
    send_cmd(lprf_pkg::CMD_BEGIN, 8'd0);
    send_cmd(lprf_pkg::CMD_BEGIN, 8'd2);
    send_cmd(lprf_pkg::CMD_BEGIN, 8'd1);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'd0);
    send_cmd(lprf_pkg::CMD_PUSH, 8'd0, 8'h00);
    send_cmd(lprf_pkg::CMD_PUSH, 8'd0, 8'hff);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'h3ff);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'd1);
    send_cmd(lprf_pkg::CMD_PEEK);
    send_cmd(lprf_pkg::CMD_PEEK);
    send_cmd(lprf_pkg::CMD_PEEK);
    send_cmd(lprf_pkg::CMD_POP);
    send_cmd(lprf_pkg::CMD_POP);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'd0);
    send_cmd(lprf_pkg::CMD_DROP);
    send_cmd(lprf_pkg::CMD_CLEAR);
  endtask

  task automatic test_fill();
    // fill the ring until full is reported, then drop and pop from it and clear it
    for (int i = 0; i < 4; i++) write_record(255);
    send_cmd(lprf_pkg::CMD_BEGIN, 8'd255);
    send_cmd(lprf_pkg::CMD_BEGIN, 8'd2);
    write_record(0);
    send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0, 10'd4);
    send_cmd(lprf_pkg::CMD_DROP);
    send_cmd(lprf_pkg::CMD_POP);
    send_cmd(lprf_pkg::CMD_DROP);
    for (int i = 0; i < 3; i++) send_cmd(lprf_pkg::CMD_POP);
    send_cmd(lprf_pkg::CMD_CLEAR);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent, k;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 35 && push_left == 0) begin
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        write_record(len);
        sent += len + 1;
      end else if (k < 55) begin
        send_cmd(lprf_pkg::CMD_POP);
        sent++;
      end else if (k < 70) begin
        send_cmd(lprf_pkg::CMD_SEL, 8'd0, 8'd0,
                 ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7)));
        send_cmd(lprf_pkg::CMD_PEEK);
        send_cmd(lprf_pkg::CMD_PEEK);
        sent += 3;
      end else if (k < 80) begin
        send_cmd(lprf_pkg::CMD_DROP);
        sent++;
      end else if (k < 82) begin
        send_cmd(lprf_pkg::CMD_CLEAR);
        sent++;
      end else begin
        // noise: any code, any operand
        send_cmd(3'($urandom), 8'($urandom_range(0, 255)), 8'($urandom), 10'($urandom));
        sent++;
      end
    end
  endtask

  // receiver stalls in a pattern of its own while stall_en is set
  always @(negedge clk_i) begin
    if (!stall_en) rsp_if.ready <= 1'b1;
    else rsp_if.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      lprf_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp_if.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, rsp_if.status); fail_cnt++;
        end
        if (rsp_if.data_out !== exp_r.data_out) begin
          $error("data_out exp %0d got %0d", exp_r.data_out, rsp_if.data_out); fail_cnt++;
        end
        if (rsp_if.record_length !== exp_r.record_length) begin
          $error("record_length exp %0d got %0d", exp_r.record_length,
                 rsp_if.record_length); fail_cnt++;
        end
        if (rsp_if.last_byte !== exp_r.last_byte) begin
          $error("last_byte exp %0d got %0d", exp_r.last_byte, rsp_if.last_byte); fail_cnt++;
        end
        if (rsp_if.records_stored !== exp_r.records_stored) begin
          $error("records_stored exp %0d got %0d", exp_r.records_stored,
                 rsp_if.records_stored); fail_cnt++;
        end
        if (rsp_if.free_bytes !== exp_r.free_bytes) begin
          $error("free_bytes exp %0d got %0d", exp_r.free_bytes, rsp_if.free_bytes); fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned drain;
    fail_cnt = 0;
    idle_cycles = 0;
    stall_en = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = lprf_pkg::CMD_CLEAR;
    req_if.record_length_in = '0;
    req_if.data_byte = '0;
    req_if.record_index = '0;
    rsp_if.ready = 1'b1;
    model_clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    stall_en = 1'b1;
    test_fill();
    test_random(200);
    stall_en = 1'b0;
    test_random(190);
    idle_req();
    drain = 0;
    while (expected_q.size() != 0 && drain < WDOG_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
